// ----- rtl/core/bsfd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bsfd_pkg
// Shared types and constants of the byte-stuffed frame decoder.
// ----------------------------------------------------------------------------
package bsfd_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int BYTE_W          = 8;
	localparam int LEN_W           = 16;
	localparam int CODE_W          = 2;
	localparam int TDATA_W         = 32;

	localparam logic [BYTE_W-1:0] BYTE_OPEN  = 8'h7E;
	localparam logic [BYTE_W-1:0] BYTE_CLOSE = 8'h7F;
	localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h7D;
	localparam logic [BYTE_W-1:0] ESC_TO_ESC   = 8'h5D;
	localparam logic [BYTE_W-1:0] ESC_TO_OPEN  = 8'h5E;
	localparam logic [BYTE_W-1:0] ESC_TO_CLOSE = 8'h5F;

	typedef enum logic [CODE_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_ESC   = 2'd1,
		STATUS_BAD_CHECK = 2'd2,
		STATUS_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              is_status;
		status_t           status_code;
		logic [LEN_W-1:0]  frame_length;
	} result_t;

endpackage
`default_nettype wire

// ----- rtl/core/bsfd_in_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bsfd_in_reg
// Input register that takes one received byte per transfer.
// ----------------------------------------------------------------------------
module bsfd_in_reg
	import bsfd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic              advance,
	output logic                   valid_s1,
	output logic [BYTE_W-1:0]      byte_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/bsfd_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bsfd_decode
// Frame state, unescaping, hold-back of the checksum byte and status logic.
// ----------------------------------------------------------------------------
module bsfd_decode
	import bsfd_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [BYTE_W-1:0] byte_s1,
	output logic                   res_valid,
	output result_t                res
);

	logic                   in_frame_q, after_escape_q, have_held_q, escape_failed_q;
	logic [BYTE_W-1:0]      held_byte_q, running_xor_q;
	logic [COUNT_WIDTH-1:0] byte_count_q;

	logic                   in_frame_d, after_escape_d, have_held_d, escape_failed_d;
	logic [BYTE_W-1:0]      held_byte_d, running_xor_d;
	logic [COUNT_WIDTH-1:0] byte_count_d;

	logic [BYTE_W-1:0]      dec_byte;
	logic                   have_dec;
	logic [LEN_W-1:0]       len_capped;

	generate
		if (COUNT_WIDTH > LEN_W) begin : g_cap
			assign len_capped = (|byte_count_q[COUNT_WIDTH-1:LEN_W]) ? {LEN_W{1'b1}}
				: byte_count_q[LEN_W-1:0];
		end else if (COUNT_WIDTH == LEN_W) begin : g_same
			assign len_capped = byte_count_q;
		end else begin : g_ext
			assign len_capped = {{(LEN_W-COUNT_WIDTH){1'b0}}, byte_count_q};
		end
	endgenerate

	always_comb begin
		dec_byte = byte_s1;
		have_dec = 1'b0;
		escape_failed_d = escape_failed_q;
		after_escape_d  = after_escape_q;
		if (after_escape_q) begin
			after_escape_d = 1'b0;
			unique case (byte_s1)
				ESC_TO_ESC: begin
					dec_byte = BYTE_ESC;
					have_dec = 1'b1;
				end
				ESC_TO_OPEN: begin
					dec_byte = BYTE_OPEN;
					have_dec = 1'b1;
				end
				ESC_TO_CLOSE: begin
					dec_byte = BYTE_CLOSE;
					have_dec = 1'b1;
				end
				default: begin
					escape_failed_d = 1'b1;
				end
			endcase
		end else if (byte_s1 == BYTE_ESC) begin
			after_escape_d = 1'b1;
		end else begin
			have_dec = 1'b1;
		end
	end

	always_comb begin
		in_frame_d    = in_frame_q;
		have_held_d   = have_held_q;
		held_byte_d   = held_byte_q;
		running_xor_d = running_xor_q;
		byte_count_d  = byte_count_q;
		res_valid     = 1'b0;
		res           = '0;
		res.status_code = STATUS_OK;

		if (!in_frame_q || byte_s1 == BYTE_OPEN || byte_s1 == BYTE_CLOSE) begin
			have_held_d   = 1'b0;
			held_byte_d   = '0;
			running_xor_d = '0;
			byte_count_d  = '0;
		end

		priority if (!in_frame_q) begin
			if (byte_s1 == BYTE_OPEN) begin
				in_frame_d = 1'b1;
			end
		end else if (byte_s1 == BYTE_OPEN) begin
			in_frame_d = 1'b1;
		end else if (byte_s1 == BYTE_CLOSE) begin
			in_frame_d    = 1'b0;
			res_valid     = 1'b1;
			res.is_status = 1'b1;
			res.frame_length = len_capped;
			priority if (escape_failed_q || after_escape_q) begin
				res.status_code = STATUS_BAD_ESC;
			end else if (!have_held_q) begin
				res.status_code = STATUS_EMPTY;
			end else if (held_byte_q != running_xor_q) begin
				res.status_code = STATUS_BAD_CHECK;
			end else begin
				res.status_code = STATUS_OK;
			end
		end else begin
			if (have_dec) begin
				held_byte_d = dec_byte;
				have_held_d = 1'b1;
				if (have_held_q) begin
					res_valid     = 1'b1;
					res.out_byte  = held_byte_q;
					running_xor_d = running_xor_q ^ held_byte_q;
					if (byte_count_q != {COUNT_WIDTH{1'b1}}) begin
						byte_count_d = byte_count_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q      <= 1'b0;
			after_escape_q  <= 1'b0;
			have_held_q     <= 1'b0;
			escape_failed_q <= 1'b0;
			held_byte_q     <= '0;
			running_xor_q   <= '0;
			byte_count_q    <= '0;
		end else if (fire) begin
			in_frame_q    <= in_frame_d;
			have_held_q   <= have_held_d;
			held_byte_q   <= held_byte_d;
			running_xor_q <= running_xor_d;
			byte_count_q  <= byte_count_d;
			if (in_frame_q && byte_s1 != BYTE_OPEN && byte_s1 != BYTE_CLOSE) begin
				after_escape_q  <= after_escape_d;
				escape_failed_q <= escape_failed_d;
			end else begin
				after_escape_q  <= 1'b0;
				escape_failed_q <= 1'b0;
			end
		end
	end

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> !have_held_q && !after_escape_q && !escape_failed_q
			&& byte_count_q == '0)
		else $error("frame state left over outside a frame");

	a_close_ends: assert property (@(posedge clk) disable iff (!arst_n)
		fire && in_frame_q && byte_s1 == BYTE_CLOSE |=> !in_frame_q)
		else $error("close did not end the frame");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid && !res.is_status |-> have_held_q && in_frame_q)
		else $error("payload transfer without a held byte");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && in_frame_q && byte_s1 != BYTE_OPEN && byte_s1 != BYTE_CLOSE
			|=> byte_count_q == $past(byte_count_q)
			|| byte_count_q == $past(byte_count_q) + 1'b1)
		else $error("byte count moved by more than one");

endmodule
`default_nettype wire

// ----- rtl/core/bsfd_out_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bsfd_out_reg
// Result register that drives the output stream.
// ----------------------------------------------------------------------------
module bsfd_out_reg
	import bsfd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    res_valid,
	input  wire result_t res,
	output logic         take,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      res_q
);

	assign take = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/byte_stuffed_frame_decoder_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stuffed_frame_decoder_unit
// Byte-stuffed deframer with XOR checksum check and end-of-frame status.
// ----------------------------------------------------------------------------
// The unit takes one raw byte per cycle while the output side keeps up: the
// byte is captured in the input register, decoded against the frame state,
// and any result lands in the output register. Each register loads whenever
// it is empty or the output register is being read, so the sustained rate is
// one byte per cycle as long as the output side keeps up.
// A payload byte appears one decoded byte late, the checksum byte never
// appears, and the status transfer of a frame carries tlast. No clearing
// pass follows reset.
module byte_stuffed_frame_decoder_unit
	import bsfd_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [BYTE_W-1:0]  s_tdata,   // rx_byte[7:0]
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata,   // out_byte[7:0], status_code[9:8],
	                                           // frame_length[25:10], zero[31:26]
	output logic                    m_tlast    // is_status
);

	logic              valid_s1, take, fire, res_valid;
	logic [BYTE_W-1:0] byte_s1;
	result_t           res, res_q;

	assign fire = valid_s1 && take;

	bsfd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.advance  (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	bsfd_decode #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	bsfd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (fire && res_valid),
		.res       (res),
		.take      (take),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res_q     (res_q)
	);

	assign m_tdata = {{(TDATA_W-BYTE_W-CODE_W-LEN_W){1'b0}}, res_q.frame_length,
		res_q.status_code, res_q.out_byte};
	assign m_tlast = res_q.is_status;

endmodule
`default_nettype wire

// ----- tb/bsfd_frame_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bsfd_frame_checker
// Predicts and checks the results of the byte-stuffed frame decoder.
// ----------------------------------------------------------------------------
// Every byte transfer on the input channel goes through a deframer model that
// keeps its own frame state and queues the payload bytes and end-of-frame
// status that the byte causes. Every transfer on the output channel is
// compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module bsfd_frame_checker
	import bsfd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	input  wire logic               s_tready,
	input  wire logic [BYTE_W-1:0]  s_tdata,   // rx_byte[7:0]
	input  wire logic               m_tvalid,
	input  wire logic               m_tready,
	input  wire logic [TDATA_W-1:0] m_tdata,   // out_byte[7:0], status_code[9:8],
	                                           // frame_length[25:10], zero[31:26]
	input  wire logic               m_tlast,   // is_status
	output int                      mismatch_count,
	output int                      pending_count
);

	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	logic                       in_frame;
	logic                       esc_pending;
	logic                       held_valid;
	logic                       esc_failed;
	logic [BYTE_W-1:0]          held_byte;
	logic [BYTE_W-1:0]          frame_xor;
	logic [COUNT_WIDTH_DEF-1:0] payload_count;
	result_t                    expected_results [$];
	int                         errors = 0;

	function automatic void drop_frame_state();
		esc_pending   = 1'b0;
		held_valid    = 1'b0;
		esc_failed    = 1'b0;
		held_byte     = '0;
		frame_xor     = '0;
		payload_count = '0;
	endfunction

	function automatic void decode_rx_byte(input logic [BYTE_W-1:0] rx);
		logic [BYTE_W-1:0] decoded;
		logic              decoded_ok;
		result_t           r;
		decoded    = rx;
		decoded_ok = 1'b0;
		r          = '0;
		if (!in_frame) begin
			if (rx == BYTE_OPEN) begin
				drop_frame_state();
				in_frame = 1'b1;
			end
		end else if (rx == BYTE_OPEN) begin
			drop_frame_state();
		end else if (rx == BYTE_CLOSE) begin
			r.is_status = 1'b1;
			if (esc_failed || esc_pending)
				r.status_code = STATUS_BAD_ESC;
			else if (!held_valid)
				r.status_code = STATUS_EMPTY;
			else if (held_byte != frame_xor)
				r.status_code = STATUS_BAD_CHECK;
			else
				r.status_code = STATUS_OK;
			r.frame_length = (payload_count > LEN_MAX) ? LEN_MAX : LEN_W'(payload_count);
			expected_results.push_back(r);
			in_frame = 1'b0;
			drop_frame_state();
		end else begin
			if (esc_pending) begin
				esc_pending = 1'b0;
				decoded_ok  = 1'b1;
				case (rx)
					ESC_TO_ESC:   decoded = BYTE_ESC;
					ESC_TO_OPEN:  decoded = BYTE_OPEN;
					ESC_TO_CLOSE: decoded = BYTE_CLOSE;
					default: begin
						decoded_ok = 1'b0;
						esc_failed = 1'b1;
					end
				endcase
			end else if (rx == BYTE_ESC) begin
				esc_pending = 1'b1;
			end else begin
				decoded_ok = 1'b1;
			end
			if (decoded_ok) begin
				if (held_valid) begin
					frame_xor = frame_xor ^ held_byte;
					if (payload_count != '1)
						payload_count = payload_count + 1'b1;
					r.out_byte = held_byte;
					expected_results.push_back(r);
				end
				held_byte  = decoded;
				held_valid = 1'b1;
			end
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
			errors++;
		end
	endfunction

	function automatic void check_result();
		result_t exp_res;
		if (expected_results.size() == 0) begin
			$error("result with no expectation: tdata 0x%0h, tlast %0b", m_tdata, m_tlast);
			errors++;
		end else begin
			exp_res = expected_results.pop_front();
			check_field("out_byte", 32'(exp_res.out_byte), 32'(m_tdata[7:0]));
			check_field("is_status", 32'(exp_res.is_status), 32'(m_tlast));
			check_field("status_code", 32'(exp_res.status_code), 32'(m_tdata[9:8]));
			check_field("frame_length", 32'(exp_res.frame_length), 32'(m_tdata[25:10]));
			check_field("tdata padding", 32'(0), 32'(m_tdata[31:26]));
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame = 1'b0;
			drop_frame_state();
			expected_results.delete();
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				decode_rx_byte(s_tdata);
		end
		pending_count  <= expected_results.size();
		mismatch_count <= errors;
	end

endmodule
`default_nettype wire

// ----- tb/byte_stuffed_frame_decoder_unit_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stuffed_frame_decoder_unit_tb
// Stimulus and verdict for the byte-stuffed frame decoder.
// ----------------------------------------------------------------------------
// A short directed stream covers stray bytes outside a frame, the empty frame,
// all three escapes, a bad escape follower, a close right after an escape
// and a restart right after an escape. Random frames of mostly small size
// follow, some of them broken, with noise between frames. Both channels idle
// in random bursts during the random frames but for the last part of the run.
// The checker beside the unit does all prediction and comparison.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_decoder_unit_tb;
	import bsfd_pkg::*;

	typedef enum int {
		FRAME_GOOD,
		FRAME_BAD_CHECK,
		FRAME_BAD_ESC,
		FRAME_RESTART,
		FRAME_ESC_CLOSE,
		FRAME_EMPTY
	} frame_kind_t;

	localparam int                QUIET_LIMIT    = 500;
	localparam int                RANDOM_ITEMS   = 700;
	localparam int                CALM_ITEMS     = 120;
	localparam int                DRAIN_CYCLES   = 10;
	localparam logic [BYTE_W-1:0] ESC_FLIP       = BYTE_ESC ^ ESC_TO_ESC;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic [BYTE_W-1:0]  s_tdata  = '0;
	logic               m_tready = 1'b0;
	wire logic          s_tready;
	wire logic          m_tvalid;
	wire logic          m_tlast;
	wire logic [TDATA_W-1:0] m_tdata;

	int mismatch_count;
	int pending_count;
	int items_sent   = 0;
	int idle_level   = 0;
	int quiet_cycles = 0;
	int stall_left   = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	byte_stuffed_frame_decoder_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	bsfd_frame_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	always @(negedge clk) begin
		if (stall_left == 0 && $urandom_range(1, 8) <= idle_level)
			stall_left = $urandom_range(1, 6);
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       pick_byte = BYTE_ESC + BYTE_W'($urandom_range(0, 2));
			1:       pick_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: pick_byte = BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] bad_follower();
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom_range(0, 255));
		while (b == ESC_TO_ESC || b == ESC_TO_OPEN || b == ESC_TO_CLOSE ||
			b == BYTE_OPEN || b == BYTE_CLOSE);
		return b;
	endfunction

	// Starts and ends at a falling edge; the byte is held until its transfer.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if ($urandom_range(1, 8) <= idle_level) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_escaped(input logic [BYTE_W-1:0] d);
		if (d == BYTE_ESC || d == BYTE_OPEN || d == BYTE_CLOSE) begin
			send_byte(BYTE_ESC);
			send_byte(d ^ ESC_FLIP);
		end else begin
			send_byte(d);
		end
	endtask

	task automatic send_frame(input frame_kind_t kind, input int n);
		logic [BYTE_W-1:0] d;
		logic [BYTE_W-1:0] sum;
		int                cut;
		sum = '0;
		cut = $urandom_range(0, n);
		send_byte(BYTE_OPEN);
		if (kind != FRAME_EMPTY) begin
			for (int i = 0; i <= n; i++) begin
				if (i == cut) begin
					if (kind == FRAME_BAD_ESC) begin
						send_byte(BYTE_ESC);
						send_byte(bad_follower());
					end else if (kind == FRAME_RESTART) begin
						if ($urandom_range(0, 1))
							send_byte(BYTE_ESC);
						send_byte(BYTE_OPEN);
						sum = '0;
					end
				end
				if (i < n) begin
					d = pick_byte();
					send_escaped(d);
					sum = sum ^ d;
				end
			end
			if (kind == FRAME_BAD_CHECK)
				sum = sum ^ (BYTE_W'(1) << $urandom_range(0, BYTE_W - 1));
			send_escaped(sum);
			if (kind == FRAME_ESC_CLOSE)
				send_byte(BYTE_ESC);
		end
		send_byte(BYTE_CLOSE);
	endtask

	initial begin
		logic [BYTE_W-1:0] directed_bytes [28] = '{
			8'hFF, 8'h7D,
			8'h7E, 8'h7F,
			8'h7E, 8'hFF, 8'h7D, 8'h5D, 8'h7D, 8'h5E, 8'h7D, 8'h5F, 8'h83, 8'h7F,
			8'h7E, 8'h7D, 8'h00, 8'h7F,
			8'h7E, 8'h11, 8'h7D, 8'h7F,
			8'h7E, 8'h22, 8'h7D, 8'h7E, 8'h00, 8'h7F
		};
		logic [BYTE_W-1:0] noise;
		frame_kind_t       kind;
		int                pick;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);

		while (items_sent < RANDOM_ITEMS) begin
			idle_level = (items_sent >= RANDOM_ITEMS - CALM_ITEMS) ? 0 : $urandom_range(0, 3);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					noise = BYTE_W'($urandom_range(0, 255));
					send_byte((noise == BYTE_OPEN) ? BYTE_CLOSE : noise);
				end
			end
			pick = $urandom_range(0, 19);
			if (pick <= 10)
				kind = FRAME_GOOD;
			else if (pick <= 12)
				kind = FRAME_BAD_CHECK;
			else if (pick <= 14)
				kind = FRAME_BAD_ESC;
			else if (pick <= 16)
				kind = FRAME_RESTART;
			else if (pick == 17)
				kind = FRAME_ESC_CLOSE;
			else
				kind = FRAME_EMPTY;
			send_frame(kind, $urandom_range(0, 3) == 0 ? $urandom_range(13, 40)
				: $urandom_range(0, 12));
		end

		s_tvalid <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire

// ----- byte_stuffed_frame_decoder_unit.f -----
rtl/core/bsfd_pkg.sv
rtl/core/bsfd_in_reg.sv
rtl/core/bsfd_decode.sv
rtl/core/bsfd_out_reg.sv
rtl/core/byte_stuffed_frame_decoder_unit.sv
tb/bsfd_frame_checker.sv
tb/byte_stuffed_frame_decoder_unit_tb.sv
